// ----- src/sat_pkg.sv -----
// sat_pkg: shared types and codes for the section address translator.
// Used by sat_ctrl, sat_datapath and section_address_translator.
// No dependencies.
package sat_pkg;

   localparam int DATA_W  = 32;
   localparam int COUNT_W = 7;
   localparam int OP_W    = 2;
   localparam int SLOT_W  = 6;

   localparam logic [OP_W-1:0] OP_WRITE_ENTRY   = 2'd0;
   localparam logic [OP_W-1:0] OP_VIRT_TO_FILE  = 2'd1;
   localparam logic [OP_W-1:0] OP_FILE_TO_VIRT  = 2'd2;

   localparam logic CSR_SECTION_COUNT   = 1'b0;
   localparam logic CSR_WIDE_IMAGE_MODE = 1'b1;

   typedef struct packed {
      logic [DATA_W-1:0] base;
      logic [DATA_W-1:0] offset;
      logic [DATA_W-1:0] length;
   } entry_type;

   typedef struct packed {
      logic capture;
      logic scan;
      logic res_hit;
      logic res_zero;
   } dp_cmd_type;

   typedef struct packed {
      logic hit;
      logic done;
   } dp_sts_type;

endpackage

// ----- src/sat_ctrl.sv -----
// sat_ctrl: beat sequencing for the section address translator.
// Depends on sat_pkg (command and status types).
module sat_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  sat_pkg::dp_sts_type sts,
   output sat_pkg::dp_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.hit) begin
               cmd.res_hit = 1'b1;
               state_in    = ST_RESP;
            end else if (sts.done) begin
               cmd.res_zero = 1'b1;
               state_in     = ST_RESP;
            end else begin
               cmd.scan = 1'b1;
            end
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

endmodule

// ----- src/sat_datapath.sv -----
// sat_datapath: section table memory, config registers, scan counter and matcher.
// Depends on sat_pkg (entry, command and status types).
module sat_datapath #(
   parameter int MAX_SECTIONS = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic                                 csr_index,
   input  logic [sat_pkg::COUNT_W-1:0]          csr_wdata,
   input  logic [sat_pkg::OP_W-1:0]             req_operation,
   input  logic [sat_pkg::SLOT_W-1:0]           req_entry_index,
   input  logic [sat_pkg::DATA_W-1:0]           req_entry_base,
   input  logic [sat_pkg::DATA_W-1:0]           req_entry_offset,
   input  logic [sat_pkg::DATA_W-1:0]           req_entry_length,
   input  logic [sat_pkg::DATA_W-1:0]           req_query_address,
   input  sat_pkg::dp_cmd_type                  cmd,
   output sat_pkg::dp_sts_type                  sts,
   output logic [sat_pkg::DATA_W-1:0]           result
);

   localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
   localparam int CNT_W = $clog2(MAX_SECTIONS + 1);

   sat_pkg::entry_type mem [MAX_SECTIONS];

   logic [sat_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                        mode_ff, mode_in;
   logic [CNT_W-1:0]            addr_ff, addr_in;
   logic                        data_vld_ff, data_vld_in;
   logic [CNT_W-1:0]            limit_ff, limit_in;
   logic                        to_file_ff, to_file_in;
   logic [sat_pkg::DATA_W-1:0]  query_ff, query_in;
   logic [sat_pkg::DATA_W-1:0]  result_ff, result_in;
   sat_pkg::entry_type          rdata_ff;

   logic [31:0]                 count_ext;
   logic [31:0]                 lim_full;
   logic [31:0]                 slot_ext;
   logic [IDX_W-1:0]            wr_addr;
   logic                        wr_ok;
   logic                        is_query;
   logic                        issue;
   logic [sat_pkg::DATA_W-1:0]  from_val, to_val, end_val, cand;
   logic                        lower_ok, match;

   // scan limit, saturated to the table depth (zero for non-queries or when off); query and write-slot decode
   always_comb begin
      count_ext = 32'(count_ff);
      lim_full  = (count_ext > 32'(MAX_SECTIONS)) ? 32'(MAX_SECTIONS) : count_ext;
      is_query  = (req_operation == sat_pkg::OP_VIRT_TO_FILE) ||
                  (req_operation == sat_pkg::OP_FILE_TO_VIRT);
      slot_ext  = 32'(req_entry_index);
      wr_addr   = slot_ext[IDX_W-1:0];
      wr_ok     = (req_operation == sat_pkg::OP_WRITE_ENTRY) &&
                  (slot_ext < 32'(MAX_SECTIONS));
   end

   always_comb begin
      count_in = count_ff;
      mode_in  = mode_ff;
      if (csr_write) begin
         case (csr_index)
            sat_pkg::CSR_SECTION_COUNT:   count_in = csr_wdata;
            sat_pkg::CSR_WIDE_IMAGE_MODE: mode_in  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign issue = (addr_ff < limit_ff);

   always_comb begin
      addr_in     = addr_ff;
      data_vld_in = data_vld_ff;
      limit_in    = limit_ff;
      to_file_in  = to_file_ff;
      query_in    = query_ff;
      if (cmd.capture) begin
         addr_in     = '0;
         data_vld_in = 1'b0;
         limit_in    = (is_query && mode_ff) ? lim_full[CNT_W-1:0] : '0;
         to_file_in  = (req_operation == sat_pkg::OP_VIRT_TO_FILE);
         query_in    = req_query_address;
      end else if (cmd.scan) begin
         data_vld_in = issue;
         if (issue) begin
            addr_in = addr_ff + CNT_W'(1);
         end
      end
   end

   // matcher on the entry read in the previous cycle
   always_comb begin
      from_val = to_file_ff ? rdata_ff.base   : rdata_ff.offset;
      to_val   = to_file_ff ? rdata_ff.offset : rdata_ff.base;
      end_val  = from_val + rdata_ff.length;
      // offset-1 < q excludes a zero offset
      lower_ok = (from_val <= query_ff) && (to_file_ff || (from_val != '0));
      match    = lower_ok && (end_val > query_ff);
      cand     = (query_ff - from_val) + to_val;
   end

   assign sts.hit  = data_vld_ff && match && (cand != '0);
   assign sts.done = !issue && !data_vld_ff;

   always_comb begin
      result_in = result_ff;
      if (cmd.res_hit) begin
         result_in = cand;
      end else if (cmd.res_zero) begin
         result_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         mode_ff     <= 1'b1;
         addr_ff     <= '0;
         data_vld_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         mode_ff     <= mode_in;
         addr_ff     <= addr_in;
         data_vld_ff <= data_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      limit_ff   <= limit_in;
      to_file_ff <= to_file_in;
      query_ff   <= query_in;
      result_ff  <= result_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture && wr_ok) begin
         mem[wr_addr] <= '{base: req_entry_base, offset: req_entry_offset,
                           length: req_entry_length};
      end
      if (cmd.scan && issue) begin
         rdata_ff <= mem[addr_ff[IDX_W-1:0]];
      end
   end

   assign result = result_ff;

endmodule

// ----- src/section_address_translator.sv -----
// section_address_translator: top level, joins sat_ctrl and sat_datapath.
// Depends on sat_pkg, sat_ctrl, sat_datapath.
//
// Usage:
//   req_* channel carries one item per beat: operation 0 stores entry
//   req_entry_index (base, offset, length); operation 1 translates a
//   virtual address to a file offset, operation 2 the reverse.
//   rsp_* channel returns one beat per item: the translation, or 0 for
//   a write, an unused operation, no match, or translation disabled.
//   csr_* writes section_count (index 0) and wide_image_mode (index 1);
//   write only while no item is in flight.
// Operation:
//   One item at a time. A query reads one table entry per cycle from a
//   single-port memory and stops at the first nonzero hit or after
//   min(section_count, MAX_SECTIONS) entries; a write, a disabled query
//   or a zero count reads no entry before the response.
//   The next item is taken the cycle after the response beat is taken.
// Reset: section_count = 0, wide_image_mode = 1, table contents undefined.
// Stall: while rsp_stall is high the response holds and req_stall stays high.
module section_address_translator #(
   parameter int MAX_SECTIONS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic                          csr_index,
   input  logic [sat_pkg::COUNT_W-1:0]   csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [sat_pkg::OP_W-1:0]      req_operation,
   input  logic [sat_pkg::SLOT_W-1:0]    req_entry_index,
   input  logic [sat_pkg::DATA_W-1:0]    req_entry_base,
   input  logic [sat_pkg::DATA_W-1:0]    req_entry_offset,
   input  logic [sat_pkg::DATA_W-1:0]    req_entry_length,
   input  logic [sat_pkg::DATA_W-1:0]    req_query_address,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sat_pkg::DATA_W-1:0]    rsp_translated_address
);

   sat_pkg::dp_cmd_type cmd;
   sat_pkg::dp_sts_type sts;

   sat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   sat_datapath #(
      .MAX_SECTIONS (MAX_SECTIONS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_operation     (req_operation),
      .req_entry_index   (req_entry_index),
      .req_entry_base    (req_entry_base),
      .req_entry_offset  (req_entry_offset),
      .req_entry_length  (req_entry_length),
      .req_query_address (req_query_address),
      .cmd               (cmd),
      .sts               (sts),
      .result            (rsp_translated_address)
   );

`ifndef NO_ASSERTIONS
   a_resp_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while a response is pending");

   a_no_instant_resp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !rsp_valid)
      else $error("response shown in the cycle after acceptance");

   a_hit_not_done: assert property (@(posedge clock) disable iff (reset)
      sts.hit |-> !sts.done)
      else $error("scan reports hit and done together");

   a_single_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.scan, cmd.res_hit, cmd.res_zero}))
      else $error("conflicting datapath commands");
`endif

endmodule

// ----- verif/tb_section_address_translator.sv -----
// tb_section_address_translator: self-checking bench for the section address translator.
// Directed table then random beats, checked against an in-bench translation predictor.
// Depends on sat_pkg and section_address_translator.
module tb_section_address_translator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOT_DEPTH       = 64;
   localparam int CYCLE_LIMIT      = 400_000;
   localparam int RANDOM_PHASES    = 10;
   localparam int PHASE_BEATS      = 62;
   localparam int LONG_HOLD_AT     = 300;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES      = 80;
   localparam logic [sat_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [sat_pkg::OP_W-1:0]   op;
      logic [sat_pkg::SLOT_W-1:0] slot;
      logic [sat_pkg::DATA_W-1:0] base;
      logic [sat_pkg::DATA_W-1:0] offset;
      logic [sat_pkg::DATA_W-1:0] length;
      logic [sat_pkg::DATA_W-1:0] query;
   } req_beat_type;

   typedef struct packed {
      logic                        en;
      logic                        idx;
      logic [sat_pkg::COUNT_W-1:0] val;
   } csr_op_type;

   typedef struct packed {
      csr_op_type                 csr;
      req_beat_type               beat;
      logic                       known;
      logic [sat_pkg::DATA_W-1:0] known_addr;
   } directed_row_type;

   localparam csr_op_type NO_CSR = '0;
   localparam int DIRECTED_ROW_COUNT = 19;

   localparam directed_row_type DIRECTED_ROWS [DIRECTED_ROW_COUNT] = '{
      // count is 0 after reset
      '{NO_CSR, '{sat_pkg::OP_VIRT_TO_FILE, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0000_1000},
        1'b1, 32'h0},
      '{NO_CSR, '{sat_pkg::OP_FILE_TO_VIRT, 6'd0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF},
        1'b1, 32'h0},
      '{NO_CSR, '{OP_UNUSED, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF}, 1'b1, 32'h0},
      '{NO_CSR, '{sat_pkg::OP_WRITE_ENTRY, 6'd0, 32'h0000_1000, 32'h0000_0200,
                  32'h0000_0100, 32'h0}, 1'b1, 32'h0},
      // end wraps to zero
      '{NO_CSR, '{sat_pkg::OP_WRITE_ENTRY, 6'd1, 32'hFFFF_FF00, 32'h0, 32'h0000_0100,
                  32'h0}, 1'b1, 32'h0},
      '{NO_CSR, '{sat_pkg::OP_WRITE_ENTRY, 6'd2, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0},
        1'b1, 32'h0},
      '{NO_CSR, '{sat_pkg::OP_WRITE_ENTRY, 6'd63, 32'h8000_0000, 32'h4000_0000,
                  32'h0000_0010, 32'hFFFF_FFFF}, 1'b1, 32'h0},
      '{'{1'b1, sat_pkg::CSR_SECTION_COUNT, 7'd3},
        '{sat_pkg::OP_VIRT_TO_FILE, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0000_1000},
        1'b1, 32'h0000_0200},
      '{NO_CSR, '{sat_pkg::OP_VIRT_TO_FILE, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0000_10FF},
        1'b1, 32'h0000_02FF},
      '{NO_CSR, '{sat_pkg::OP_VIRT_TO_FILE, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0000_1100},
        1'b0, 32'h0},
      // match with zero translation is skipped
      '{NO_CSR, '{sat_pkg::OP_VIRT_TO_FILE, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0},
        1'b1, 32'h0},
      '{NO_CSR, '{sat_pkg::OP_FILE_TO_VIRT, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0000_0200},
        1'b1, 32'h0000_1000},
      '{NO_CSR, '{sat_pkg::OP_FILE_TO_VIRT, 6'd0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF},
        1'b0, 32'h0},
      '{NO_CSR, '{sat_pkg::OP_VIRT_TO_FILE, 6'd0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FF80},
        1'b0, 32'h0},
      '{NO_CSR, '{sat_pkg::OP_FILE_TO_VIRT, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0000_0080},
        1'b0, 32'h0},
      // translation off, upper data bits set
      '{'{1'b1, sat_pkg::CSR_WIDE_IMAGE_MODE, 7'h7E},
        '{sat_pkg::OP_VIRT_TO_FILE, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0000_1000},
        1'b1, 32'h0},
      '{NO_CSR, '{sat_pkg::OP_FILE_TO_VIRT, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0000_0200},
        1'b1, 32'h0},
      '{NO_CSR, '{sat_pkg::OP_WRITE_ENTRY, 6'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'h0}, 1'b1, 32'h0},
      '{'{1'b1, sat_pkg::CSR_WIDE_IMAGE_MODE, 7'h01},
        '{sat_pkg::OP_VIRT_TO_FILE, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0000_1000},
        1'b1, 32'h0000_0200}
   };

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         csr_write = 1'b0;
   logic                         csr_index = 1'b0;
   logic [sat_pkg::COUNT_W-1:0]  csr_wdata = '0;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [sat_pkg::OP_W-1:0]     req_operation = '0;
   logic [sat_pkg::SLOT_W-1:0]   req_entry_index = '0;
   logic [sat_pkg::DATA_W-1:0]   req_entry_base = '0;
   logic [sat_pkg::DATA_W-1:0]   req_entry_offset = '0;
   logic [sat_pkg::DATA_W-1:0]   req_entry_length = '0;
   logic [sat_pkg::DATA_W-1:0]   req_query_address = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [sat_pkg::DATA_W-1:0]   rsp_translated_address;

   logic [sat_pkg::DATA_W-1:0]   model_base   [SLOT_DEPTH];
   logic [sat_pkg::DATA_W-1:0]   model_offset [SLOT_DEPTH];
   logic [sat_pkg::DATA_W-1:0]   model_length [SLOT_DEPTH];
   logic [sat_pkg::COUNT_W-1:0]  model_count = '0;
   logic                         model_wide = 1'b1;

   logic [sat_pkg::DATA_W-1:0]   expected_addresses [$];
   int                           beats_sent = 0;
   int                           results_checked = 0;
   int                           csr_writes = 0;
   int                           errors = 0;
   int                           cycle_count = 0;

   section_address_translator #(.MAX_SECTIONS(SLOT_DEPTH)) uut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_addresses.size());
      $display("tb_section_address_translator: errors");
      $finish;
   end

   task automatic note_failure(input string what, input logic [sat_pkg::DATA_W-1:0] want,
                               input logic [sat_pkg::DATA_W-1:0] got);
      errors++;
      if (errors <= 10)
         $display("%0t: %s: expected %08h, got %08h", $realtime, what, want, got);
   endtask

   // Writes update the table; queries scan entries in order, first nonzero answer wins.
   function automatic logic [sat_pkg::DATA_W-1:0] predict_translation(input req_beat_type b);
      logic [sat_pkg::DATA_W-1:0] from_side, to_side, span_end, low_edge, answer;
      int unsigned lim, i;
      if (b.op == sat_pkg::OP_WRITE_ENTRY) begin
         model_base[b.slot]   = b.base;
         model_offset[b.slot] = b.offset;
         model_length[b.slot] = b.length;
         return '0;
      end
      if (!model_wide || b.op == OP_UNUSED)
         return '0;
      lim = (model_count > SLOT_DEPTH) ? SLOT_DEPTH : model_count;
      for (i = 0; i < lim; i++) begin
         from_side = (b.op == sat_pkg::OP_VIRT_TO_FILE) ? model_base[i] : model_offset[i];
         to_side   = (b.op == sat_pkg::OP_VIRT_TO_FILE) ? model_offset[i] : model_base[i];
         span_end  = from_side + model_length[i];
         low_edge  = from_side - 32'd1;
         answer    = b.query - from_side + to_side;
         if (span_end > b.query && answer != '0) begin
            if (b.op == sat_pkg::OP_VIRT_TO_FILE ? (from_side <= b.query)
                                                 : (low_edge < b.query))
               return answer;
         end
      end
      return '0;
   endfunction

   function automatic req_beat_type random_beat();
      req_beat_type b;
      int unsigned pick, lim, i;
      logic [sat_pkg::DATA_W-1:0] from_side, span;
      b.op     = sat_pkg::OP_WRITE_ENTRY;
      b.slot   = sat_pkg::SLOT_W'($urandom);
      b.base   = $urandom;
      b.offset = $urandom;
      b.length = $urandom;
      b.query  = $urandom;
      pick = $urandom_range(99);
      lim  = (model_count > SLOT_DEPTH) ? SLOT_DEPTH : model_count;
      if (pick < 20) begin
         case ($urandom_range(9))
            0: b.length = '0;
            1: b.length = '1;
            2, 3: ;
            default: b.length = $urandom_range(4096, 1);
         endcase
      end else if (pick < 25) begin
         b.op = OP_UNUSED;
      end else if (pick < 85) begin
         i = $urandom_range((lim == 0) ? SLOT_DEPTH - 1 : lim - 1);
         b.op = $urandom_range(1) ? sat_pkg::OP_VIRT_TO_FILE : sat_pkg::OP_FILE_TO_VIRT;
         from_side = (b.op == sat_pkg::OP_VIRT_TO_FILE) ? model_base[i] : model_offset[i];
         span = model_length[i];
         case ($urandom_range(3))
            0: b.query = from_side;
            1: b.query = from_side + span - 32'd1;
            2: b.query = from_side + span;
            default: b.query = from_side + ((span == '0) ? '0 : $urandom % span);
         endcase
      end else begin
         b.op = $urandom_range(1) ? sat_pkg::OP_VIRT_TO_FILE : sat_pkg::OP_FILE_TO_VIRT;
      end
      return b;
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_beat(input req_beat_type b, input logic known,
                            input logic [sat_pkg::DATA_W-1:0] known_addr, input int gap);
      logic [sat_pkg::DATA_W-1:0] predicted;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_operation     = b.op;
      req_entry_index   = b.slot;
      req_entry_base    = b.base;
      req_entry_offset  = b.offset;
      req_entry_length  = b.length;
      req_query_address = b.query;
      req_valid         = 1'b1;
      do @(posedge clock); while (req_stall);
      predicted = predict_translation(b);
      expected_addresses.push_back(known ? known_addr : predicted);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid = 1'b0;
      while (expected_addresses.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [sat_pkg::COUNT_W-1:0] val);
      wait_idle();
      csr_write = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_write = 1'b0;
      if (idx == sat_pkg::CSR_SECTION_COUNT)
         model_count = val;
      else
         model_wide = val[0];
      csr_writes++;
   endtask

   initial begin : rsp_side
      int  hold;
      bit  calm;
      bit  long_hold_done;
      logic [sat_pkg::DATA_W-1:0] want;
      calm = 1'b0;
      long_hold_done = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (results_checked % 64 == 0)
            calm = ($urandom_range(2) == 0);
         if (results_checked == LONG_HOLD_AT && !long_hold_done) begin
            hold = LONG_HOLD_CYCLES;
            long_hold_done = 1'b1;
         end else begin
            hold = calm ? 0 : $urandom_range(12);
         end
         if (hold > 0) begin
            rsp_stall = 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         if (expected_addresses.size() == 0) begin
            note_failure("result beat with nothing pending", '0, rsp_translated_address);
         end else begin
            want = expected_addresses.pop_front();
            if (rsp_translated_address !== want)
               note_failure("translated_address", want, rsp_translated_address);
         end
         results_checked++;
         @(negedge clock);
      end
   end

   initial begin : req_side
      req_beat_type                b;
      logic [sat_pkg::COUNT_W-1:0] v;
      int                          r, s, p, n;
      bit                          burst;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      for (r = 0; r < DIRECTED_ROW_COUNT; r++) begin
         if (DIRECTED_ROWS[r].csr.en)
            write_csr(DIRECTED_ROWS[r].csr.idx, DIRECTED_ROWS[r].csr.val);
         send_beat(DIRECTED_ROWS[r].beat, DIRECTED_ROWS[r].known,
                   DIRECTED_ROWS[r].known_addr, $urandom_range(3));
      end

      // fill every slot so any count scans written entries only
      for (s = 0; s < SLOT_DEPTH; s++) begin
         b = random_beat();
         b.op = sat_pkg::OP_WRITE_ENTRY;
         b.slot = sat_pkg::SLOT_W'(s);
         b.length = $urandom_range(4096, 1);
         b.query = $urandom;
         send_beat(b, 1'b0, '0, $urandom_range(12));
      end

      for (p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: v = 7'd64;
            1: v = 7'd1;
            2: v = 7'd127;
            3: v = 7'd0;
            4: v = sat_pkg::COUNT_W'($urandom_range(126, 65));
            default: v = sat_pkg::COUNT_W'($urandom_range(64, 1));
         endcase
         write_csr(sat_pkg::CSR_SECTION_COUNT, v);
         v = sat_pkg::COUNT_W'($urandom);
         v[0] = (p != 5);
         write_csr(sat_pkg::CSR_WIDE_IMAGE_MODE, v);
         burst = (p % 3 == 1);
         for (n = 0; n < PHASE_BEATS; n++)
            send_beat(random_beat(), 1'b0, '0, burst ? 0 : $urandom_range(12));
      end

      wait_idle();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (expected_addresses.size() != 0)
         note_failure("results never returned",
                      sat_pkg::DATA_W'(expected_addresses.size()), '0);
      $display("sent %0d beats (%0d from the directed table), checked %0d results",
               beats_sent, DIRECTED_ROW_COUNT, results_checked);
      $display("%0d register writes over %0d phases, %0d mismatches, %0d cycles",
               csr_writes, RANDOM_PHASES, errors, cycle_count);
      if (errors == 0)
         $display("tb_section_address_translator: clean");
      else
         $display("tb_section_address_translator: errors");
      $finish;
   end

endmodule

// ----- files.f -----
src/sat_pkg.sv
src/sat_ctrl.sv
src/sat_datapath.sv
src/section_address_translator.sv
verif/tb_section_address_translator.sv
